[rtl/ecp_pkg.sv]
package ecp_pkg;

    localparam int MAX_BUFFER  = 65536;
    localparam int MAX_ENTRIES = 8191;
    localparam int HDR_BYTES   = 8;

    localparam int LEN_W = 17;
    localparam int IDX_W = 13;
    localparam int REM_W = 16;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 104;
    localparam int M_TUSER_W = 3;

    localparam logic [2:0] ROLE_HDR    = 3'd0;
    localparam logic [2:0] ROLE_FINAL  = 3'd1;
    localparam logic [2:0] ROLE_NAME   = 3'd2;
    localparam logic [2:0] ROLE_NUL    = 3'd3;
    localparam logic [2:0] ROLE_VALUE  = 3'd4;
    localparam logic [2:0] ROLE_OTHER  = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NAME_PAST = 2'd1;
    localparam logic [1:0] ST_SHORT     = 2'd2;

    // One classified byte, handed from the front to the back.
    typedef struct packed {
        logic [2:0]       role;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
        logic [63:0]      hdr;
        logic             kept;
        logic [IDX_W-1:0] count;
        logic [1:0]       status;
        logic             last;
    } t_rec;

endpackage

[rtl/ecp_front.sv]
module ecp_front
    import ecp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic [LEN_W-1:0] i_blen,
    input  logic             i_last,
    output t_rec             o_rec
);

    typedef enum logic [2:0] {
        PH_HDR,
        PH_NAME,
        PH_TERM,
        PH_VALUE,
        PH_GAP
    } t_phase;

    t_phase           r_phase, n_phase, w_ph;
    logic [LEN_W-1:0] r_position, n_position;
    logic [LEN_W-1:0] r_entry_start, n_entry_start;
    logic [LEN_W-1:0] r_len, n_len;
    logic [55:0]      r_shift, n_shift;
    logic [63:0]      r_hdr, n_hdr;
    logic [REM_W-1:0] r_rem, n_rem;
    logic             r_nul, n_nul;
    logic             r_walk_done, n_walk_done;
    logic             r_value_ok, n_value_ok;
    logic             r_stop, n_stop;
    logic [IDX_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_ent_idx, n_ent_idx;

    logic             w_wd;
    logic [2:0]       w_k;
    logic [63:0]      w_h;
    logic [31:0]      w_nxo;
    logic [7:0]       w_nl;
    logic [15:0]      w_vl;
    logic [LEN_W:0]   w_name_end;
    logic [LEN_W:0]   w_val_end;
    logic [LEN_W-1:0] w_span;
    logic             w_short;
    logic [32:0]      w_nstart;
    logic [LEN_W-1:0] w_nclamp;
    logic             w_nul_now;
    logic [REM_W-1:0] w_rem_dec;

    always_comb begin
        n_len = r_len;
        if (r_position == '0) begin
            n_len = (i_blen > LEN_W'(MAX_BUFFER)) ? LEN_W'(MAX_BUFFER) : i_blen;
        end

        n_position    = r_position;
        n_entry_start = r_entry_start;
        n_shift       = r_shift;
        n_hdr         = r_hdr;
        n_rem         = r_rem;
        n_nul         = r_nul;
        n_value_ok    = r_value_ok;
        n_stop        = r_stop;
        n_count       = r_count;
        n_ent_idx     = r_ent_idx;

        w_wd = r_walk_done || (r_position >= n_len);
        w_ph = r_phase;
        if (!w_wd && w_ph == PH_GAP && r_position == r_entry_start) begin
            w_ph    = PH_HDR;
            n_shift = '0;
        end
        if (!w_wd && w_ph == PH_HDR &&
            ({1'b0, r_entry_start} + (LEN_W+1)'(HDR_BYTES) > {1'b0, n_len})) begin
            w_wd = 1'b1;
        end
        n_phase     = w_ph;
        n_walk_done = w_wd;

        w_k        = r_position[2:0] - r_entry_start[2:0];
        w_h        = {i_byte, n_shift};
        w_nxo      = w_h[31:0];
        w_nl       = w_h[47:40];
        w_vl       = w_h[63:48];
        w_name_end = {1'b0, r_entry_start} + (LEN_W+1)'(HDR_BYTES) + (LEN_W+1)'(w_nl);
        w_val_end  = {1'b0, r_entry_start} + (LEN_W+1)'(HDR_BYTES + 1)
                     + (LEN_W+1)'(w_nl) + (LEN_W+1)'(w_vl);
        w_span     = LEN_W'(HDR_BYTES + 1) + LEN_W'(w_nl) + LEN_W'(w_vl);
        w_short    = (w_nxo != '0) && (w_nxo < 32'(w_span));
        w_nstart   = 33'(r_entry_start) + 33'(w_nxo);
        w_nclamp   = (w_nstart > 33'(n_len)) ? n_len : w_nstart[LEN_W-1:0];
        w_nul_now  = r_nul || (i_byte == 8'd0);
        w_rem_dec  = (r_rem != '0) ? r_rem - REM_W'(1) : r_rem;

        o_rec        = '0;
        o_rec.role   = ROLE_OTHER;
        o_rec.data   = i_byte;
        o_rec.idx    = (w_wd || w_ph == PH_HDR) ? r_count : r_ent_idx;
        o_rec.status = ST_OK;
        o_rec.last   = i_last;

        if (!w_wd) begin
            unique case (w_ph)
                PH_HDR: begin
                    if (w_k != 3'd7) begin
                        n_shift    = n_shift | (56'(i_byte) << {w_k, 3'b000});
                        o_rec.role = ROLE_HDR;
                    end else begin
                        n_hdr      = w_h;
                        n_shift    = '0;
                        o_rec.hdr  = w_h;
                        o_rec.role = ROLE_FINAL;
                        n_ent_idx  = r_count;
                        o_rec.idx  = r_count;
                        if (w_name_end > {1'b0, n_len}) begin
                            o_rec.status = ST_NAME_PAST;
                            n_walk_done  = 1'b1;
                        end else begin
                            if (r_count != IDX_W'(MAX_ENTRIES)) begin
                                n_count = r_count + IDX_W'(1);
                            end
                            n_value_ok    = (w_val_end <= {1'b0, n_len});
                            o_rec.kept    = n_value_ok;
                            o_rec.status  = w_short ? ST_SHORT : ST_OK;
                            n_stop        = (w_nxo == '0) || w_short;
                            n_entry_start = w_nclamp;
                            n_nul         = 1'b0;
                            n_rem         = REM_W'(w_nl);
                            n_phase       = (w_nl != '0) ? PH_NAME : PH_TERM;
                        end
                    end
                end
                PH_NAME: begin
                    n_nul      = w_nul_now;
                    o_rec.role = w_nul_now ? ROLE_NUL : ROLE_NAME;
                    o_rec.kept = r_value_ok;
                    n_rem      = w_rem_dec;
                    if (w_rem_dec == '0) begin
                        n_phase = PH_TERM;
                    end
                end
                PH_TERM: begin
                    o_rec.role = ROLE_NUL;
                    o_rec.kept = r_value_ok;
                    n_rem      = r_hdr[63:48];
                    if (r_hdr[63:48] != '0) begin
                        n_phase = PH_VALUE;
                    end else if (r_stop) begin
                        n_walk_done = 1'b1;
                    end else begin
                        n_phase = PH_GAP;
                    end
                end
                PH_VALUE: begin
                    o_rec.role = r_value_ok ? ROLE_VALUE : ROLE_OTHER;
                    o_rec.kept = r_value_ok;
                    n_rem      = w_rem_dec;
                    if (w_rem_dec == '0) begin
                        if (r_stop) begin
                            n_walk_done = 1'b1;
                        end else begin
                            n_phase = PH_GAP;
                        end
                    end
                end
                default: begin
                    o_rec.role = ROLE_OTHER;
                end
            endcase
        end

        o_rec.count = n_count;

        if (r_position != LEN_W'(MAX_BUFFER)) begin
            n_position = r_position + LEN_W'(1);
        end
    end

    // A byte with last set returns the walk to its start for the next buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_phase       <= PH_HDR;
            r_position    <= '0;
            r_entry_start <= '0;
            r_len         <= '0;
            r_shift       <= '0;
            r_hdr         <= '0;
            r_rem         <= '0;
            r_nul         <= 1'b0;
            r_walk_done   <= 1'b0;
            r_value_ok    <= 1'b0;
            r_stop        <= 1'b0;
            r_count       <= '0;
            r_ent_idx     <= '0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_position    <= n_position;
            r_entry_start <= n_entry_start;
            r_len         <= n_len;
            r_shift       <= n_shift;
            r_hdr         <= n_hdr;
            r_rem         <= n_rem;
            r_nul         <= n_nul;
            r_walk_done   <= n_walk_done;
            r_value_ok    <= n_value_ok;
            r_stop        <= n_stop;
            r_count       <= n_count;
            r_ent_idx     <= n_ent_idx;
        end
    end

endmodule

[rtl/ecp_queue.sv]
module ecp_queue
    import ecp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_rec o_rec
);

    t_rec       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_level, n_level;

    assign o_full  = (r_level == 2'd2);
    assign o_empty = (r_level == 2'd0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_level  = r_level + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

endmodule

[rtl/ecp_back.sv]
module ecp_back
    import ecp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    input  t_rec                 i_rec,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    logic [7:0]           r_mask;
    logic                 r_valid;
    logic [M_TDATA_W-1:0] r_tdata, n_tdata;
    logic [M_TUSER_W-1:0] r_tuser;
    logic                 r_tlast;
    logic                 w_final;
    logic                 w_need;

    assign o_pop    = !i_empty && (!r_valid || m_tready);
    assign m_tvalid = r_valid;
    assign m_tdata  = r_tdata;
    assign m_tuser  = r_tuser;
    assign m_tlast  = r_tlast;

    always_comb begin
        w_final = (i_rec.role == ROLE_FINAL);
        w_need  = w_final && ((i_rec.hdr[39:32] & r_mask) != 8'd0);
        n_tdata = '0;
        n_tdata[7:0]    = i_rec.data;
        n_tdata[20:8]   = i_rec.idx;
        n_tdata[86]     = i_rec.kept;
        n_tdata[99:87]  = i_rec.count;
        n_tdata[101:100] = i_rec.status;
        if (w_final) begin
            n_tdata[52:21] = i_rec.hdr[31:0];
            n_tdata[60:53] = i_rec.hdr[39:32];
            n_tdata[61]    = w_need;
            n_tdata[69:62] = i_rec.hdr[47:40];
            n_tdata[85:70] = i_rec.hdr[63:48];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= 8'd128;
            r_valid <= 1'b0;
            r_tdata <= '0;
            r_tuser <= '0;
            r_tlast <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_valid <= 1'b1;
                r_tdata <= n_tdata;
                r_tuser <= i_rec.role;
                r_tlast <= i_rec.last;
            end else if (m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

[rtl/ea_entry_chain_parser.sv]
// Walks a chain of extended-attribute entries, one buffer byte per request.
// The slave channel takes one byte with its buffer length; s_tlast marks the
// final byte of a buffer and clears the walk so the next byte opens a new one.
// Every accepted byte yields exactly one request on the master channel, in
// order, carrying the byte's role in m_tuser and the decoded header, indexes,
// counts and status in m_tdata.
// The front decodes a byte in the cycle it is accepted and writes the result
// into a two-entry queue; the back moves it into the output register.
// One byte is taken every cycle while the receiver keeps up. When m_tready is
// low the output register holds, the queue fills and s_tready drops once both
// queue entries are occupied; no request is lost.
// The user must write the need-flag mask through i_cfg_we and i_cfg_wdata only
// while the block is idle; the block does not enforce this. Reset sets the mask
// to 128, empties the queue and the output register, and starts a new buffer.
module ea_entry_chain_parser
    import ecp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // data_byte[7:0], buffer_length[24:8]
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // byte_out[7:0], entry_index[20:8], next_offset[52:21], entry_flags[60:53],
    // need_ea[61], name_length[69:62], value_length[85:70], value_kept[86],
    // entry_count[99:87], status[101:100]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,  // role[2:0]
    output logic                 m_tlast
);

    t_rec w_front_rec;
    t_rec w_queue_rec;
    logic w_full;
    logic w_empty;
    logic w_pop;
    logic w_accept;

    assign s_tready = !w_full;
    assign w_accept = s_tvalid && !w_full;

    ecp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_tdata[7:0]),
        .i_blen   (s_tdata[24:8]),
        .i_last   (s_tlast),
        .o_rec    (w_front_rec)
    );

    ecp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_rec   (w_front_rec),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_rec   (w_queue_rec)
    );

    ecp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rec       (w_queue_rec),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

[tb/ea_entry_chain_parser_checker.sv]
module ea_entry_chain_parser_checker
    import ecp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 m_tlast,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_results,
    output int                   o_headers,
    output int                   o_stopped
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        WALK_HDR,
        WALK_NAME,
        WALK_TERM,
        WALK_VALUE,
        WALK_GAP
    } t_walk_phase;

    typedef struct packed {
        logic [1:0]  pad;
        logic [1:0]  status;
        logic [12:0] count;
        logic        kept;
        logic [15:0] vlen;
        logic [7:0]  nlen;
        logic        need;
        logic [7:0]  flags;
        logic [31:0] nxo;
        logic [12:0] idx;
        logic [7:0]  data;
    } t_byte_fields;

    typedef struct packed {
        logic [2:0]   role;
        logic         last;
        t_byte_fields f;
    } t_classified_byte;

    logic [7:0]       need_mask;
    logic [16:0]      position;
    logic [16:0]      entry_start;
    logic [16:0]      remaining;
    logic [16:0]      latched_len;
    t_walk_phase      phase;
    logic [63:0]      hdr_shift;
    logic [63:0]      cur_hdr;
    logic             nul_seen;
    logic             walk_done;
    logic             value_ok;
    logic             stop_after;
    logic [12:0]      accepted;
    logic [12:0]      cur_idx;
    t_classified_byte expected_bytes[$];

    task automatic clear_walk();
        position    = '0;
        entry_start = '0;
        remaining   = '0;
        latched_len = '0;
        phase       = WALK_HDR;
        hdr_shift   = '0;
        cur_hdr     = '0;
        nul_seen    = 1'b0;
        walk_done   = 1'b0;
        value_ok    = 1'b0;
        stop_after  = 1'b0;
        accepted    = '0;
        cur_idx     = '0;
    endtask

    task automatic finish_entry();
        if (stop_after) begin
            walk_done = 1'b1;
        end else begin
            phase = WALK_GAP;
        end
    endtask

    task automatic classify_byte(input logic [7:0] b, input logic [16:0] blen,
                                 input logic last, output t_classified_byte r);
        logic [63:0] hdr;
        logic [63:0] span;
        logic [63:0] nstart;
        logic [16:0] len;
        logic [2:0]  k;
        r = '0;
        r.role = ROLE_OTHER;
        r.last = last;
        r.f.data = b;
        if (position == 0) begin
            latched_len = (blen > 17'(MAX_BUFFER)) ? 17'(MAX_BUFFER) : blen;
        end
        len = latched_len;
        if (position >= len) begin
            walk_done = 1'b1;
        end
        if (!walk_done && phase == WALK_GAP && position == entry_start) begin
            phase = WALK_HDR;
            hdr_shift = '0;
        end
        if (!walk_done && phase == WALK_HDR
                && 64'(entry_start) + 64'(HDR_BYTES) > 64'(len)) begin
            walk_done = 1'b1;
        end
        r.f.idx = (walk_done || phase == WALK_HDR) ? accepted : cur_idx;
        if (!walk_done) begin
            case (phase)
                WALK_HDR: begin
                    k = 3'(position - entry_start);
                    if (k != 3'd7) begin
                        hdr_shift = hdr_shift | (64'(b) << (8 * k));
                        r.role = ROLE_HDR;
                    end else begin
                        hdr = hdr_shift | (64'(b) << 56);
                        cur_hdr = hdr;
                        hdr_shift = '0;
                        r.f.nxo = hdr[31:0];
                        r.f.flags = hdr[39:32];
                        r.f.nlen = hdr[47:40];
                        r.f.vlen = hdr[63:48];
                        r.f.need = (hdr[39:32] & need_mask) != 8'd0;
                        r.role = ROLE_FINAL;
                        cur_idx = accepted;
                        r.f.idx = cur_idx;
                        if (64'(entry_start) + 64'(HDR_BYTES) + 64'(hdr[47:40]) > 64'(len)) begin
                            r.f.status = ST_NAME_PAST;
                            walk_done = 1'b1;
                        end else begin
                            if (accepted < 13'(MAX_ENTRIES)) begin
                                accepted++;
                            end
                            span = 64'(HDR_BYTES) + 64'd1 + 64'(hdr[47:40]) + 64'(hdr[63:48]);
                            value_ok = 64'(entry_start) + span <= 64'(len);
                            r.f.kept = value_ok;
                            r.f.status = (hdr[31:0] != 0 && 64'(hdr[31:0]) < span)
                                ? ST_SHORT : ST_OK;
                            stop_after = hdr[31:0] == 0 || r.f.status == ST_SHORT;
                            nstart = 64'(entry_start) + 64'(hdr[31:0]);
                            entry_start = (nstart > 64'(len)) ? len : nstart[16:0];
                            nul_seen = 1'b0;
                            remaining = 17'(hdr[47:40]);
                            phase = (hdr[47:40] != 0) ? WALK_NAME : WALK_TERM;
                        end
                    end
                end
                WALK_NAME: begin
                    if (b == 8'd0) begin
                        nul_seen = 1'b1;
                    end
                    r.role = nul_seen ? ROLE_NUL : ROLE_NAME;
                    r.f.kept = value_ok;
                    if (remaining > 0) begin
                        remaining--;
                    end
                    if (remaining == 0) begin
                        phase = WALK_TERM;
                    end
                end
                WALK_TERM: begin
                    r.role = ROLE_NUL;
                    r.f.kept = value_ok;
                    remaining = 17'(cur_hdr[63:48]);
                    if (remaining != 0) begin
                        phase = WALK_VALUE;
                    end else begin
                        finish_entry();
                    end
                end
                WALK_VALUE: begin
                    r.role = value_ok ? ROLE_VALUE : ROLE_OTHER;
                    r.f.kept = value_ok;
                    if (remaining > 0) begin
                        remaining--;
                    end
                    if (remaining == 0) begin
                        finish_entry();
                    end
                end
                default: begin
                    r.role = ROLE_OTHER;
                end
            endcase
        end
        r.f.count = accepted;
        if (position < 17'(MAX_BUFFER)) begin
            position++;
        end
        if (last) begin
            clear_walk();
        end
    endtask

    function automatic string show_byte(t_classified_byte r);
        return $sformatf({"role=%0d byte=%02h idx=%0d nxo=%08h flags=%02h need=%0d",
                          " nlen=%0d vlen=%0d kept=%0d count=%0d status=%0d last=%0d pad=%0d"},
                         r.role, r.f.data, r.f.idx, r.f.nxo, r.f.flags, r.f.need,
                         r.f.nlen, r.f.vlen, r.f.kept, r.f.count, r.f.status, r.last, r.f.pad);
    endfunction

    function automatic string differing_fields(t_classified_byte e, t_classified_byte a);
        string s;
        s = "";
        if (a.role !== e.role) s = {s, " role"};
        if (a.last !== e.last) s = {s, " last"};
        if (a.f.data !== e.f.data) s = {s, " byte_out"};
        if (a.f.idx !== e.f.idx) s = {s, " entry_index"};
        if (a.f.nxo !== e.f.nxo) s = {s, " next_offset"};
        if (a.f.flags !== e.f.flags) s = {s, " entry_flags"};
        if (a.f.need !== e.f.need) s = {s, " need_ea"};
        if (a.f.nlen !== e.f.nlen) s = {s, " name_length"};
        if (a.f.vlen !== e.f.vlen) s = {s, " value_length"};
        if (a.f.kept !== e.f.kept) s = {s, " value_kept"};
        if (a.f.count !== e.f.count) s = {s, " entry_count"};
        if (a.f.status !== e.f.status) s = {s, " status"};
        if (a.f.pad !== e.f.pad) s = {s, " padding"};
        return s;
    endfunction

    task automatic count_mismatch(input string msg);
        o_mismatches++;
        if (o_mismatches <= 10) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_classified_byte exp_r;
        t_classified_byte act_r;
        string bad;
        if (!i_rst_n) begin
            need_mask = 8'd128;
            clear_walk();
            expected_bytes.delete();
            o_mismatches = 0;
            o_results = 0;
            o_headers = 0;
            o_stopped = 0;
        end else begin
            if (i_cfg_we) begin
                need_mask = i_cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                classify_byte(s_tdata[7:0], s_tdata[24:8], s_tlast, exp_r);
                expected_bytes = {expected_bytes, exp_r};
            end
            if (m_tvalid && m_tready) begin
                act_r = {m_tuser, m_tlast, m_tdata};
                o_results++;
                if (expected_bytes.size() == 0) begin
                    count_mismatch($sformatf("Request %0d arrived with nothing expected: %s",
                                             o_results, show_byte(act_r)));
                end else begin
                    exp_r = expected_bytes.pop_front();
                    if (exp_r.role == ROLE_FINAL) begin
                        o_headers++;
                        if (exp_r.f.status != ST_OK) begin
                            o_stopped++;
                        end
                    end
                    bad = differing_fields(exp_r, act_r);
                    if (bad != "") begin
                        count_mismatch($sformatf({"Request %0d differs in%s.\n",
                                                  "  expected %s\n  actual   %s"},
                                                 o_results, bad, show_byte(exp_r),
                                                 show_byte(act_r)));
                    end
                end
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

[tb/ea_entry_chain_parser_tb.sv]
module ea_entry_chain_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ecp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 320;
    localparam int LONG_HOLD   = 150;

    typedef struct {
        logic [7:0]  b;
        logic [16:0] blen;
        logic        last;
    } t_stream_byte;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [7:0]           i_cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    int mismatches;
    int pending;
    int results;
    int headers;
    int stopped;

    int send_burst = 0;
    int recv_burst = 0;
    int n_bytes = 0;
    int n_buffers = 0;
    int n_mask_writes = 0;
    int cycles = 0;
    t_stream_byte buffer_bytes[$];

    always #5 i_clk = ~i_clk;

    ea_entry_chain_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    ea_entry_chain_parser_checker chain_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .o_mismatches(mismatches),
        .o_pending   (pending),
        .o_results   (results),
        .o_headers   (headers),
        .o_stopped   (stopped)
    );

    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic [16:0] blen, input logic last);
        t_stream_byte sb;
        sb.b = b;
        sb.blen = blen;
        sb.last = last;
        buffer_bytes = {buffer_bytes, sb};
    endtask

    task automatic send_byte(input t_stream_byte sb);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            s_tdata = $urandom;
            s_tlast = 1'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {7'd0, sb.blen, sb.b};
        s_tlast = sb.last;
        do @(posedge i_clk); while (!s_tready);
        n_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_buffer();
        foreach (buffer_bytes[i]) begin
            send_byte(buffer_bytes[i]);
        end
        n_buffers++;
        buffer_bytes.delete();
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_mask(input logic [7:0] mask);
        i_cfg_we = 1'b1;
        i_cfg_wdata = mask;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        n_mask_writes++;
    endtask

    // A chain of one to four entries, sometimes cut short, padded, ended early or
    // given an oversized length; otherwise a buffer of plain noise.
    task automatic build_buffer();
        logic [7:0]  raw[$];
        logic [31:0] nxo;
        logic [16:0] blen;
        logic [15:0] vl;
        logic [7:0]  nl;
        int          n_entries;
        int          name_bytes;
        int          value_bytes;
        int          span;
        int          gap;
        int          total;
        int          variant;
        bit          junk_len;
        if ($urandom_range(0, 9) < 2) begin
            repeat ($urandom_range(1, 40)) raw = {raw, 8'($urandom)};
            blen = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(1, 60));
        end else begin
            n_entries = $urandom_range(1, 4);
            for (int e = 0; e < n_entries; e++) begin
                nl = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
                vl = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
                name_bytes = int'(nl);
                value_bytes = int'(vl);
                if (e == n_entries - 1 && $urandom_range(0, 9) == 0) begin
                    vl = 16'($urandom_range(9, 65535));
                    value_bytes = $urandom_range(0, 8);
                end
                if (e == n_entries - 1 && $urandom_range(0, 14) == 0) begin
                    nl = 8'($urandom_range(200, 255));
                    name_bytes = $urandom_range(0, 8);
                end
                span = 9 + int'(nl) + int'(vl);
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                if (e == n_entries - 1) begin
                    nxo = ($urandom_range(0, 9) < 7) ? 32'd0 : 32'($urandom);
                end else begin
                    case ($urandom_range(0, 19))
                        0: nxo = 32'($urandom_range(1, span - 1));
                        1: nxo = 32'($urandom);
                        default: nxo = 32'(span + gap);
                    endcase
                end
                for (int i = 0; i < 4; i++) begin
                    raw = {raw, nxo[8*i +: 8]};
                end
                raw = {raw, 8'($urandom)};
                raw = {raw, nl};
                raw = {raw, vl[7:0]};
                raw = {raw, vl[15:8]};
                repeat (name_bytes) begin
                    raw = {raw, (($urandom_range(0, 6) == 0) ? 8'd0
                                                             : 8'($urandom_range(1, 255)))};
                end
                raw = {raw, (($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'd0)};
                repeat (value_bytes) raw = {raw, 8'($urandom)};
                if (e != n_entries - 1) begin
                    repeat (gap) raw = {raw, 8'($urandom)};
                end
            end
            total = raw.size();
            blen = 17'(total);
            variant = $urandom_range(0, 9);
            case (variant)
                0: begin
                    blen = 17'($urandom_range(1, total));
                    while (raw.size() > blen) raw.pop_back();
                end
                1: repeat ($urandom_range(1, 4)) raw = {raw, 8'($urandom)};
                2: begin
                    total = $urandom_range(1, total);
                    while (raw.size() > total) raw.pop_back();
                end
                3: blen = 17'($urandom_range(65537, 131071));
                default: ;
            endcase
        end
        junk_len = $urandom_range(0, 4) == 0;
        foreach (raw[i]) begin
            queue_byte(raw[i], (i != 0 && junk_len) ? 17'($urandom) : blen, i == raw.size() - 1);
        end
    endtask

    initial begin : receiver
        int gap;
        int taken;
        taken = 0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = draw_gap(recv_burst);
            if (taken == 300 || taken == 1000) begin
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready = 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            taken++;
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("ea_entry_chain_parser_tb failed");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] mask_plan[5];
        logic [7:0] mask;
        int         phase_bytes;
        mask_plan = '{8'h00, 8'hFF, 8'h01, 8'h00, 8'h80};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // A buffer whose length is zero.
        queue_byte(8'hFF, 17'd0, 1'b1);
        // Oversized length with a single entry that ends the chain.
        for (int i = 0; i < 8; i++) begin
            queue_byte((i == 4) ? 8'h80 : 8'h00, 17'h1FFFF, 1'b0);
        end
        queue_byte(8'h00, 17'h1FFFF, 1'b1);
        // The header does not fit, and one byte runs past the length.
        for (int i = 0; i < 6; i++) begin
            queue_byte(8'hFF, 17'd5, i == 5);
        end
        // An all-ones header whose name runs past the end.
        for (int i = 0; i < 9; i++) begin
            queue_byte(8'hFF, 17'd9, i == 8);
        end
        send_buffer();

        for (int p = 0; p < 5; p++) begin
            drain();
            mask = (p == 3) ? 8'($urandom) : mask_plan[p];
            write_mask(mask);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                build_buffer();
                phase_bytes += buffer_bytes.size();
                send_buffer();
            end
        end
        drain();
        repeat (4) @(negedge i_clk);

        $display("Streamed %0d bytes in %0d buffers under %0d need-mask settings.",
                 n_bytes, n_buffers, n_mask_writes + 1);
        $display("Checked %0d requests, %0d entry headers, %0d of them ending the walk early.",
                 results, headers, stopped);
        if (mismatches == 0) begin
            $display("ea_entry_chain_parser_tb passed");
        end else begin
            $display("ea_entry_chain_parser_tb failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/ecp_pkg.sv
rtl/ecp_front.sv
rtl/ecp_queue.sv
rtl/ecp_back.sv
rtl/ea_entry_chain_parser.sv
tb/ea_entry_chain_parser_checker.sv
tb/ea_entry_chain_parser_tb.sv
